// ----- rtl/dpsp_pkg.sv -----
package dpsp_pkg;

  // Converter width and fixed-point percent format (hundredths of a percent)
  localparam int ADC_BITS_DEF  = 12;
  localparam int PCT_BITS      = 14;
  localparam int PCT_FULL      = 10000;
  localparam int SHORT_GAP     = 5;
  localparam int MARGIN_BITS   = 10;
  localparam int LIMIT_BITS    = 14;
  localparam int CFG_IDX_BITS  = 3;
  localparam int OUT_DATA_BITS = 16;

  // Pipeline depth: check stage, multiply stage, one stage per quotient bit, merge
  localparam int DIV_STEPS   = PCT_BITS;
  localparam int LANE_STAGES = 2 + DIV_STEPS;
  localparam int PIPE_STAGES = LANE_STAGES + 1;

  // Register reset values
  localparam int A_MIN_RST  = 880;
  localparam int A_MAX_RST  = 2720;
  localparam int B_MIN_RST  = 300;
  localparam int B_MAX_RST  = 2600;
  localparam int MARGIN_RST = 80;
  localparam int LIMIT_RST  = 1000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_A_MIN  = 3'd0,
    REG_A_MAX  = 3'd1,
    REG_B_MIN  = 3'd2,
    REG_B_MAX  = 3'd3,
    REG_MARGIN = 3'd4,
    REG_LIMIT  = 3'd5
  } cfg_reg_t;

  // What one sensor lane hands to the merge stage
  typedef struct packed {
    logic [PCT_BITS-1:0] pct;
    logic                range_ok;
  } lane_res_t;

endpackage

// ----- rtl/dpsp_lane.sv -----
module dpsp_lane #(
  parameter int ADC_BITS = dpsp_pkg::ADC_BITS_DEF
) (
  input  logic                               clk,
  input  logic [dpsp_pkg::LANE_STAGES-1:0]   en,
  input  logic [ADC_BITS-1:0]                sample,
  input  logic [ADC_BITS-1:0]                cal_min,
  input  logic [ADC_BITS-1:0]                cal_max,
  input  logic [dpsp_pkg::MARGIN_BITS-1:0]   margin,
  output dpsp_pkg::lane_res_t                res
);

  localparam int VW = (ADC_BITS > dpsp_pkg::MARGIN_BITS) ? ADC_BITS : dpsp_pkg::MARGIN_BITS;
  localparam int SW = VW + 2;
  localparam int PW = ADC_BITS + dpsp_pkg::PCT_BITS;
  localparam int NS = dpsp_pkg::DIV_STEPS;
  localparam logic [ADC_BITS-1:0] SHORT_LO = ADC_BITS'(dpsp_pkg::SHORT_GAP);
  localparam logic [ADC_BITS-1:0] SHORT_HI =
    ADC_BITS'((2 ** ADC_BITS) - 1 - dpsp_pkg::SHORT_GAP);

  // Range check and signed offsets
  logic [ADC_BITS-1:0]        lo, hi;
  logic signed [SW-1:0]       raw_s, lo_s, hi_s, mg_s;
  logic                       short_hit, span_ok;
  logic signed [ADC_BITS:0]   num, den, num_neg;
  logic [ADC_BITS-1:0]        n_mag, d_mag;
  logic signed [ADC_BITS:0]   den_neg;
  logic                       zero_c;

  always_comb begin
    lo        = (cal_min < cal_max) ? cal_min : cal_max;
    hi        = (cal_min < cal_max) ? cal_max : cal_min;
    raw_s     = $signed(SW'(sample));
    lo_s      = $signed(SW'(lo));
    hi_s      = $signed(SW'(hi));
    mg_s      = $signed(SW'(margin));
    short_hit = (sample <= SHORT_LO) || (sample >= SHORT_HI);
    span_ok   = (raw_s >= lo_s - mg_s) && (raw_s <= hi_s + mg_s);
    num       = $signed({1'b0, sample}) - $signed({1'b0, cal_min});
    den       = $signed({1'b0, cal_max}) - $signed({1'b0, cal_min});
    num_neg   = -num;
    den_neg   = -den;
    n_mag     = num[ADC_BITS] ? num_neg[ADC_BITS-1:0] : num[ADC_BITS-1:0];
    d_mag     = den[ADC_BITS] ? den_neg[ADC_BITS-1:0] : den[ADC_BITS-1:0];
    // empty span, or sample on the far side of min: percent is zero
    zero_c    = (den == '0) || (num[ADC_BITS] != den[ADC_BITS]);
  end

  // Stage 0: hold magnitudes and flags
  logic                s0_ok, s0_zero;
  logic [ADC_BITS-1:0] s0_n, s0_d;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_ok   <= !short_hit && span_ok;
      s0_zero <= zero_c;
      s0_n    <= n_mag;
      s0_d    <= d_mag;
    end
  end

  // Stage 1: scale the numerator, flag saturation at full span
  logic                s1_ok, s1_zero, s1_full;
  logic [ADC_BITS-1:0] s1_d;
  logic [PW-1:0]       s1_prod;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_ok   <= s0_ok;
      s1_zero <= s0_zero;
      s1_full <= (s0_n >= s0_d);
      s1_d    <= s0_d;
      s1_prod <= PW'(s0_n) * PW'(dpsp_pkg::PCT_FULL);
    end
  end

  // Restoring divider, one quotient bit per stage. Numerator is below
  // d * 2^14 whenever the quotient is used, so the top bits seed the remainder.
  logic [ADC_BITS-1:0]          drem  [NS];
  logic [dpsp_pkg::PCT_BITS-1:0] dw   [NS];
  logic [ADC_BITS-1:0]          dd    [NS];
  logic                         dok   [NS];
  logic                         dzero [NS];
  logic                         dfull [NS];

  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [ADC_BITS-1:0]           rem_in, d_in;
    logic [dpsp_pkg::PCT_BITS-1:0] w_in;
    logic                          ok_in, zero_in, full_in;
    logic [ADC_BITS:0]             trial, trial_sub;
    logic                          ge;

    if (k == 0) begin : g_first
      assign rem_in  = s1_prod[PW-1:dpsp_pkg::PCT_BITS];
      assign w_in    = s1_prod[dpsp_pkg::PCT_BITS-1:0];
      assign d_in    = s1_d;
      assign ok_in   = s1_ok;
      assign zero_in = s1_zero;
      assign full_in = s1_full;
    end else begin : g_next
      assign rem_in  = drem[k-1];
      assign w_in    = dw[k-1];
      assign d_in    = dd[k-1];
      assign ok_in   = dok[k-1];
      assign zero_in = dzero[k-1];
      assign full_in = dfull[k-1];
    end

    always_comb begin
      trial     = {rem_in, w_in[dpsp_pkg::PCT_BITS-1]};
      trial_sub = trial - {1'b0, d_in};
      ge        = (trial >= {1'b0, d_in});
    end

    always_ff @(posedge clk) begin
      if (en[2+k]) begin
        drem[k]  <= ge ? trial_sub[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
        dw[k]    <= {w_in[dpsp_pkg::PCT_BITS-2:0], ge};
        dd[k]    <= d_in;
        dok[k]   <= ok_in;
        dzero[k] <= zero_in;
        dfull[k] <= full_in;
      end
    end
  end

  // Clamp and pick the lane result
  always_comb begin
    res.range_ok = dok[NS-1];
    if (dzero[NS-1]) begin
      res.pct = '0;
    end else if (dfull[NS-1]) begin
      res.pct = dpsp_pkg::PCT_BITS'(dpsp_pkg::PCT_FULL);
    end else begin
      res.pct = dw[NS-1];
    end
  end

endmodule

// ----- rtl/dpsp_merge.sv -----
module dpsp_merge (
  input  logic                               clk,
  input  logic                               en,
  input  dpsp_pkg::lane_res_t                lane_a,
  input  dpsp_pkg::lane_res_t                lane_b,
  input  logic [dpsp_pkg::LIMIT_BITS-1:0]    limit,
  output logic [dpsp_pkg::PCT_BITS-1:0]      throttle_percent,
  output logic                               reading_valid
);

  logic [dpsp_pkg::PCT_BITS:0]   pct_sum;
  logic [dpsp_pkg::PCT_BITS-1:0] pct_diff;
  logic                          agree;

  // Mean and absolute disagreement of the two lanes
  always_comb begin
    pct_sum  = {1'b0, lane_a.pct} + {1'b0, lane_b.pct};
    pct_diff = (lane_a.pct >= lane_b.pct) ? (lane_a.pct - lane_b.pct)
                                          : (lane_b.pct - lane_a.pct);
    agree    = (dpsp_pkg::LIMIT_BITS'(pct_diff) <= limit);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      throttle_percent <= pct_sum[dpsp_pkg::PCT_BITS:1];
      reading_valid    <= lane_a.range_ok && lane_b.range_ok && agree;
    end
  end

endmodule

// ----- rtl/dual_pedal_sensor_plausibility.sv -----
// Channel  Direction  Handshake          Payload
// s_       in         s_tvalid/s_tready  s_tdata: sample_a, sample_b
// m_       out        m_tvalid/m_tready  m_tdata: throttle_percent; m_tuser: reading_valid
// cfg_     in         cfg_wr_en          cfg_index, cfg_data
//
// The pipeline is a check stage, a multiply stage, 14 divider stages
// (one quotient bit each) in both sensor lanes, and the merge/output register.
// One transaction is taken per cycle while the output drains.
// Reset is synchronous; it empties the pipeline and reloads the calibration.
// A stalled output holds; earlier stages keep filling bubbles, so input is
// still taken until every stage is occupied.
module dual_pedal_sensor_plausibility #(
  parameter int ADC_BITS = dpsp_pkg::ADC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // sample_a, sample_b, zero pad
  input  logic [((2*ADC_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // throttle_percent, zero pad
  output logic [dpsp_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  // reading_valid
  output logic [0:0]                           m_tuser,
  input  logic                                 cfg_wr_en,
  input  logic [dpsp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [((ADC_BITS > dpsp_pkg::LIMIT_BITS) ? ADC_BITS : dpsp_pkg::LIMIT_BITS)-1:0]
                                               cfg_data
);

  localparam int NP = dpsp_pkg::PIPE_STAGES;
  localparam int NL = dpsp_pkg::LANE_STAGES;

  // Calibration registers
  logic [ADC_BITS-1:0]              a_min, a_max, b_min, b_max;
  logic [dpsp_pkg::MARGIN_BITS-1:0] span_margin;
  logic [dpsp_pkg::LIMIT_BITS-1:0]  mismatch_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_min          <= ADC_BITS'(dpsp_pkg::A_MIN_RST);
      a_max          <= ADC_BITS'(dpsp_pkg::A_MAX_RST);
      b_min          <= ADC_BITS'(dpsp_pkg::B_MIN_RST);
      b_max          <= ADC_BITS'(dpsp_pkg::B_MAX_RST);
      span_margin    <= dpsp_pkg::MARGIN_BITS'(dpsp_pkg::MARGIN_RST);
      mismatch_limit <= dpsp_pkg::LIMIT_BITS'(dpsp_pkg::LIMIT_RST);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dpsp_pkg::REG_A_MIN:  a_min          <= cfg_data[ADC_BITS-1:0];
        dpsp_pkg::REG_A_MAX:  a_max          <= cfg_data[ADC_BITS-1:0];
        dpsp_pkg::REG_B_MIN:  b_min          <= cfg_data[ADC_BITS-1:0];
        dpsp_pkg::REG_B_MAX:  b_max          <= cfg_data[ADC_BITS-1:0];
        dpsp_pkg::REG_MARGIN: span_margin    <= cfg_data[dpsp_pkg::MARGIN_BITS-1:0];
        dpsp_pkg::REG_LIMIT:  mismatch_limit <= cfg_data[dpsp_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Stage occupancy; a stage loads when it is empty or its successor moves
  logic [NP-1:0] stage_valid;
  logic [NP-1:0] stage_en;

  always_comb begin
    stage_en[NP-1] = !stage_valid[NP-1] || m_tready;
    for (int i = NP - 2; i >= 0; i--) begin
      stage_en[i] = !stage_valid[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      for (int i = 0; i < NP; i++) begin
        if (stage_en[i]) begin
          stage_valid[i] <= (i == 0) ? s_tvalid : stage_valid[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign s_tready = stage_en[0];
  assign m_tvalid = stage_valid[NP-1];

  // One lane per sensor
  dpsp_pkg::lane_res_t res_a, res_b;

  dpsp_lane #(.ADC_BITS(ADC_BITS)) u_lane_a (
    .clk     (clk),
    .en      (stage_en[NL-1:0]),
    .sample  (s_tdata[ADC_BITS-1:0]),
    .cal_min (a_min),
    .cal_max (a_max),
    .margin  (span_margin),
    .res     (res_a)
  );

  dpsp_lane #(.ADC_BITS(ADC_BITS)) u_lane_b (
    .clk     (clk),
    .en      (stage_en[NL-1:0]),
    .sample  (s_tdata[2*ADC_BITS-1:ADC_BITS]),
    .cal_min (b_min),
    .cal_max (b_max),
    .margin  (span_margin),
    .res     (res_b)
  );

  // Combine the lanes into the output register
  logic [dpsp_pkg::PCT_BITS-1:0] throttle_percent;
  logic                          reading_valid;

  dpsp_merge u_merge (
    .clk              (clk),
    .en               (stage_en[NP-1]),
    .lane_a           (res_a),
    .lane_b           (res_b),
    .limit            (mismatch_limit),
    .throttle_percent (throttle_percent),
    .reading_valid    (reading_valid)
  );

  assign m_tdata = dpsp_pkg::OUT_DATA_BITS'(throttle_percent);
  assign m_tuser = reading_valid;

`ifndef SYNTHESIS
  // Output percent never exceeds full scale
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (throttle_percent <= dpsp_pkg::PCT_BITS'(dpsp_pkg::PCT_FULL)))
    else $error("throttle percent above full scale");

  // Input is refused only when the first stage holds a transaction
  a_ready_stage: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> stage_valid[0])
    else $error("input refused with empty first stage");

  // A free output lets the whole pipeline advance
  a_free_flow: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> (&stage_en))
    else $error("pipeline stalled while output is free");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int ADC_FULL  = (1 << dpsp_pkg::ADC_BITS_DEF) - 1;
  localparam int S_BITS    = ((2 * dpsp_pkg::ADC_BITS_DEF + 7) / 8) * 8;
  localparam int CFG_BITS  = (dpsp_pkg::ADC_BITS_DEF > dpsp_pkg::LIMIT_BITS) ?
                             dpsp_pkg::ADC_BITS_DEF : dpsp_pkg::LIMIT_BITS;
  localparam int RAND_ITEMS = 135;

  // Register indexes the block decodes to nothing
  localparam logic [dpsp_pkg::CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [dpsp_pkg::CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

  typedef enum int {RX_OPEN, RX_LIGHT_STALL, RX_HEAVY_STALL, RX_BURSTY} rx_mode_t;

  typedef struct {
    logic [dpsp_pkg::PCT_BITS-1:0] pct;
    logic                          ok;
  } reading_t;

  // Predicts throttle readings from sensor pairs and checks the block's output
  class pct_scoreboard;
    logic [dpsp_pkg::ADC_BITS_DEF-1:0] a_min, a_max, b_min, b_max;
    logic [dpsp_pkg::MARGIN_BITS-1:0]  margin;
    logic [dpsp_pkg::LIMIT_BITS-1:0]   limit;
    reading_t                          expected_q[$];
    int                                errors;
    int                                n_checked;
    int                                n_valid;

    function new();
      a_min  = dpsp_pkg::ADC_BITS_DEF'(dpsp_pkg::A_MIN_RST);
      a_max  = dpsp_pkg::ADC_BITS_DEF'(dpsp_pkg::A_MAX_RST);
      b_min  = dpsp_pkg::ADC_BITS_DEF'(dpsp_pkg::B_MIN_RST);
      b_max  = dpsp_pkg::ADC_BITS_DEF'(dpsp_pkg::B_MAX_RST);
      margin = dpsp_pkg::MARGIN_BITS'(dpsp_pkg::MARGIN_RST);
      limit  = dpsp_pkg::LIMIT_BITS'(dpsp_pkg::LIMIT_RST);
    endfunction

    function void set_reg(logic [dpsp_pkg::CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
      case (idx)
        dpsp_pkg::REG_A_MIN:  a_min  = v[dpsp_pkg::ADC_BITS_DEF-1:0];
        dpsp_pkg::REG_A_MAX:  a_max  = v[dpsp_pkg::ADC_BITS_DEF-1:0];
        dpsp_pkg::REG_B_MIN:  b_min  = v[dpsp_pkg::ADC_BITS_DEF-1:0];
        dpsp_pkg::REG_B_MAX:  b_max  = v[dpsp_pkg::ADC_BITS_DEF-1:0];
        dpsp_pkg::REG_MARGIN: margin = v[dpsp_pkg::MARGIN_BITS-1:0];
        dpsp_pkg::REG_LIMIT:  limit  = v[dpsp_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Shorted sample or outside the widened span fails
    function bit sample_in_range(int raw, int mn, int mx);
      int lo, hi;
      lo = (mn < mx) ? mn : mx;
      hi = (mn < mx) ? mx : mn;
      if (raw <= dpsp_pkg::SHORT_GAP || raw >= ADC_FULL - dpsp_pkg::SHORT_GAP) return 0;
      return (raw >= lo - int'(margin)) && (raw <= hi + int'(margin));
    endfunction

    // Raw count to hundredths of a percent, truncated toward zero and clamped
    function int raw_to_pct(int raw, int mn, int mx);
      int q;
      if (mx == mn) return 0;
      q = ((raw - mn) * dpsp_pkg::PCT_FULL) / (mx - mn);
      if (q < 0) return 0;
      if (q > dpsp_pkg::PCT_FULL) return dpsp_pkg::PCT_FULL;
      return q;
    endfunction

    function void note_sample(logic [dpsp_pkg::ADC_BITS_DEF-1:0] a,
                              logic [dpsp_pkg::ADC_BITS_DEF-1:0] b);
      int pa, pb, diff, mean;
      reading_t want;
      pa   = raw_to_pct(int'(a), int'(a_min), int'(a_max));
      pb   = raw_to_pct(int'(b), int'(b_min), int'(b_max));
      diff = (pa > pb) ? pa - pb : pb - pa;
      mean = (pa + pb) / 2;
      want.pct = mean[dpsp_pkg::PCT_BITS-1:0];
      want.ok  = sample_in_range(int'(a), int'(a_min), int'(a_max)) &&
                 sample_in_range(int'(b), int'(b_min), int'(b_max)) &&
                 (diff <= int'(limit));
      expected_q.push_back(want);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_reading(logic [dpsp_pkg::PCT_BITS-1:0] pct, logic ok);
      reading_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("reading pct=%0d valid=%0b with nothing pending", pct, ok));
        return;
      end
      want = expected_q.pop_front();
      if (pct !== want.pct)
        report($sformatf("throttle_percent mismatch: got %0d, want %0d", pct, want.pct));
      if (ok !== want.ok)
        report($sformatf("reading_valid mismatch: got %0b, want %0b (pct %0d)",
                         ok, want.ok, want.pct));
      n_checked++;
      if (ok === 1'b1) n_valid++;
    endtask
  endclass

  logic                               clk;
  logic                               rst;
  logic                               s_tvalid;
  logic                               s_tready;
  // sample_a, sample_b, zero pad
  logic [S_BITS-1:0]                  s_tdata;
  logic                               m_tvalid;
  logic                               m_tready;
  // throttle_percent, zero pad
  logic [dpsp_pkg::OUT_DATA_BITS-1:0] m_tdata;
  // reading_valid
  logic [0:0]                         m_tuser;
  logic                               cfg_wr_en;
  logic [dpsp_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_BITS-1:0]                cfg_data;

  pct_scoreboard sb = new();
  int            n_settings;

  dual_pedal_sensor_plausibility u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the output on a changing pattern
  initial begin
    rx_mode_t mode;
    int       left;
    int       hold;
    m_tready = 1'b0;
    mode     = RX_OPEN;
    left     = 0;
    hold     = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(50, 300);
      end
      left--;
      case (mode)
        RX_OPEN:        m_tready = 1'b1;
        RX_LIGHT_STALL: m_tready = ($urandom_range(0, 9) < 7);
        RX_HEAVY_STALL: m_tready = ($urandom_range(0, 9) < 3);
        default: begin
          if (hold == 0) begin
            hold     = $urandom_range(1, 24);
            m_tready = ~m_tready;
          end
          hold--;
        end
      endcase
    end
  end

  // Check every output transaction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_reading(m_tdata[dpsp_pkg::PCT_BITS-1:0], m_tuser[0]);
  end

  initial begin
    #5ms;
    $display("timeout: %0d readings still pending", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int clamp_raw(int v);
    if (v < 0) return 0;
    if (v > ADC_FULL) return ADC_FULL;
    return v;
  endfunction

  // Raw count at fraction t/10000 of the span; t may run past either end
  function automatic int along_span(int mn, int mx, int t);
    return clamp_raw(mn + ((mx - mn) * t) / dpsp_pkg::PCT_FULL);
  endfunction

  // Raw counts at the rails, the short thresholds, the widened span edges and the span ends
  function automatic int edge_raw(int mn, int mx, int mg);
    int lo, hi;
    lo = (mn < mx) ? mn : mx;
    hi = (mn < mx) ? mx : mn;
    case ($urandom_range(0, 11))
      0:  return 0;
      1:  return dpsp_pkg::SHORT_GAP;
      2:  return dpsp_pkg::SHORT_GAP + 1;
      3:  return ADC_FULL - dpsp_pkg::SHORT_GAP - 1;
      4:  return ADC_FULL - dpsp_pkg::SHORT_GAP;
      5:  return ADC_FULL;
      6:  return clamp_raw(lo - mg - 1);
      7:  return clamp_raw(lo - mg);
      8:  return clamp_raw(hi + mg);
      9:  return clamp_raw(hi + mg + 1);
      10: return mn;
      default: return mx;
    endcase
  endfunction

  // Mostly pairs that track each other, some edge cases, some noise
  task automatic pick_pair(output int a, output int b);
    int kind, t, tb_t;
    kind = $urandom_range(0, 9);
    t    = $urandom_range(0, 13000) - 1500;
    tb_t = t + $urandom_range(0, 2400) - 1200;
    if (kind < 6) begin
      a = along_span(int'(sb.a_min), int'(sb.a_max), t);
      b = along_span(int'(sb.b_min), int'(sb.b_max), tb_t);
    end else if (kind == 6) begin
      a = edge_raw(int'(sb.a_min), int'(sb.a_max), int'(sb.margin));
      b = along_span(int'(sb.b_min), int'(sb.b_max), tb_t);
    end else if (kind == 7) begin
      a = along_span(int'(sb.a_min), int'(sb.a_max), t);
      b = edge_raw(int'(sb.b_min), int'(sb.b_max), int'(sb.margin));
    end else begin
      a = $urandom_range(0, ADC_FULL);
      b = $urandom_range(0, ADC_FULL);
    end
  endtask

  task automatic send_pair(int a, int b);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = '0;
    s_tdata[dpsp_pkg::ADC_BITS_DEF-1:0] = dpsp_pkg::ADC_BITS_DEF'(a);
    s_tdata[2*dpsp_pkg::ADC_BITS_DEF-1:dpsp_pkg::ADC_BITS_DEF] = dpsp_pkg::ADC_BITS_DEF'(b);
    do @(posedge clk); while (!s_tready);
    sb.note_sample(dpsp_pkg::ADC_BITS_DEF'(a), dpsp_pkg::ADC_BITS_DEF'(b));
  endtask

  // Drop valid and put noise on the data bus
  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = S_BITS'($urandom);
    end
  endtask

  // Pause the sender until every pending reading has come out
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [dpsp_pkg::CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Load a full calibration; junk goes into the bits above each register but the limit
  task automatic load_setting(int amn, int amx, int bmn, int bmx, int mg, int lim);
    write_reg(dpsp_pkg::REG_A_MIN,  CFG_BITS'(amn) |
              (CFG_BITS'($urandom_range(0, 3)) << dpsp_pkg::ADC_BITS_DEF));
    write_reg(dpsp_pkg::REG_A_MAX,  CFG_BITS'(amx) |
              (CFG_BITS'($urandom_range(0, 3)) << dpsp_pkg::ADC_BITS_DEF));
    write_reg(dpsp_pkg::REG_B_MIN,  CFG_BITS'(bmn) |
              (CFG_BITS'($urandom_range(0, 3)) << dpsp_pkg::ADC_BITS_DEF));
    write_reg(dpsp_pkg::REG_B_MAX,  CFG_BITS'(bmx) |
              (CFG_BITS'($urandom_range(0, 3)) << dpsp_pkg::ADC_BITS_DEF));
    write_reg(dpsp_pkg::REG_MARGIN, CFG_BITS'(mg) |
              (CFG_BITS'($urandom_range(0, 15)) << dpsp_pkg::MARGIN_BITS));
    write_reg(dpsp_pkg::REG_LIMIT,  CFG_BITS'(lim));
    n_settings++;
  endtask

  task automatic load_random_setting();
    int amn, amx, bmn, bmx, mg, lim;
    amn = $urandom_range(0, ADC_FULL);
    amx = ($urandom_range(0, 7) == 0) ? amn : $urandom_range(0, ADC_FULL);
    bmn = $urandom_range(0, ADC_FULL);
    bmx = ($urandom_range(0, 7) == 0) ? bmn : $urandom_range(0, ADC_FULL);
    mg  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 120);
    lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 2000);
    load_setting(amn, amx, bmn, bmx, mg, lim);
  endtask

  // Random pairs in bursts of random length with random gaps
  task automatic run_pairs(int count);
    int a, b;
    int burst;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < count; i++) begin
      pick_pair(a, b);
      send_pair(a, b);
      burst--;
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
        burst = $urandom_range(1, 40);
      end
      if ($urandom_range(0, 199) == 0) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    n_settings = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset calibration: shorts, span edges, full scale, agreement edges
    send_pair(0, 0);
    send_pair(ADC_FULL, ADC_FULL);
    send_pair(dpsp_pkg::SHORT_GAP, dpsp_pkg::SHORT_GAP);
    send_pair(dpsp_pkg::SHORT_GAP + 1, dpsp_pkg::SHORT_GAP + 1);
    send_pair(ADC_FULL - dpsp_pkg::SHORT_GAP - 1, ADC_FULL - dpsp_pkg::SHORT_GAP - 1);
    send_pair(ADC_FULL - dpsp_pkg::SHORT_GAP, ADC_FULL - dpsp_pkg::SHORT_GAP);
    send_pair(800, 220);
    send_pair(799, 219);
    send_pair(2800, 2680);
    send_pair(2801, 2681);
    send_pair(880, 300);
    send_pair(2720, 2600);
    send_pair(1800, 1450);
    send_pair(880, 2600);
    send_pair(1064, 530);
    send_pair(1064, 531);
    hold_off(3);
    send_pair(2730, 1365);
    send_pair(1365, 2730);
    send_pair(2720, 300);
    wait_idle();
    run_pairs(RAND_ITEMS);

    // Widest span on A, inverted full span on B, no margin, zero limit
    load_setting(0, ADC_FULL, ADC_FULL, 0, 0, 0);
    run_pairs(RAND_ITEMS);

    // Empty span on A, largest margin, limit at full scale
    load_setting(2000, 2000, 100, 3900, 1023, dpsp_pkg::PCT_FULL);
    run_pairs(RAND_ITEMS);

    // Inverted span on A, empty span on B, limit above full scale
    load_setting(3000, 1000, ADC_FULL, ADC_FULL, 1023, (1 << dpsp_pkg::LIMIT_BITS) - 1);
    run_pairs(RAND_ITEMS);

    // Writes to unused indexes must leave the calibration alone
    load_setting(880, 2720, 300, 2600, 80, 1000);
    write_reg(REG_SPARE_6, CFG_BITS'($urandom));
    write_reg(REG_SPARE_7, CFG_BITS'($urandom));
    run_pairs(RAND_ITEMS);

    repeat (4) begin
      load_random_setting();
      run_pairs(RAND_ITEMS);
    end

    // Watch for stray readings after the last one
    wait_idle();
    repeat (dpsp_pkg::PIPE_STAGES + 8) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d readings never came out", sb.pending()));

    $display("Checked %0d sensor pairs over %0d calibration settings.",
             sb.n_checked, n_settings);
    $display("%0d readings flagged valid, %0d flagged invalid; %0d mismatches.",
             sb.n_valid, sb.n_checked - sb.n_valid, sb.errors);
    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
